>>> hdl/pedal_pulse_frequency_monitor_defines.svh
// Assertion macros for the checker of the pulse frequency monitor.
`ifndef PEDAL_PULSE_FREQUENCY_MONITOR_DEFINES_SVH
`define PEDAL_PULSE_FREQUENCY_MONITOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define PPFM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define PPFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ppfm_pkg.sv
// Shared types, widths and constants of the pulse frequency monitor.
package ppfm_pkg;

  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_STEP_W = $clog2(DIVIDEND_W + 1);

  localparam logic [DIV_STEP_W-1:0] DIV_STEPS_FREQ = DIV_STEP_W'(32);
  localparam logic [DIV_STEP_W-1:0] DIV_STEPS_RPM  = DIV_STEP_W'(DIVIDEND_W);

  localparam logic [15:0] FREQ_MILLI_SCALE = 16'd1000;
  localparam logic [15:0] RPM_MILLI_SCALE  = 16'd60000;

  localparam logic [31:0] TIMER_CLOCK_RESET = 32'd84000000;
  localparam logic [15:0] GAP_LIMIT_RESET   = 16'd500;
  localparam logic [7:0]  MAGNET_RESET      = 8'd1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_IDX_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMER_CLOCK  = 8'd0,
    REG_GAP_LIMIT    = 8'd1,
    REG_MAGNET_COUNT = 8'd2
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_CAPTURE = 1'b0,
    KIND_TICK    = 1'b1
  } item_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_FREQ,
    ST_MUL_FREQ,
    ST_MUL_RPM,
    ST_DIV_RPM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_ctrl_t;

endpackage

>>> hdl/ppfm_div.sv
// Restoring divider that resolves one quotient bit per cycle.
module ppfm_div import ppfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  div_ctrl_t             ctrl,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic                  busy;
  logic [DIV_STEP_W-1:0] count;
  logic [DIVIDEND_W-1:0] q;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, q[DIVIDEND_W-1]};
    fits     = shifted >= {1'b0, dvsr};
    diff     = shifted - {1'b0, dvsr};
    rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= ctrl.steps;
      end else if (busy) begin
        count <= count - DIV_STEP_W'(1);
        if (count == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the partial remainder left, take one quotient bit in at the bottom.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      q    <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      q   <= {q[DIVIDEND_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = q;

endmodule

>>> hdl/pedal_pulse_frequency_monitor.sv
// Top level of the pedal pulse frequency monitor.
// Takes capture and tick words and returns one result word per input word:
// frequency in millihertz (saturated to 32 bits), rpm in milli-rpm (saturated
// to 38 bits) and the low-frequency flag. A capture word stores the period
// and marks a pulse pending; a tick word refreshes the frequency from the
// held period and judges the pending pulse or the silence against the gap
// limit. All division runs on one shared restoring divider that resolves a
// single quotient bit per cycle. A tick that computes a new frequency takes a
// 32-step pass for clock / period, and every word takes a 48-step pass for
// the rpm division unless the magnet count is zero. One word is worked on at
// a time; s_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next word may be taken
// while a finished result waits on m_tready. Configuration writes are always
// accepted and must come only while the block is idle.
module pedal_pulse_frequency_monitor import ppfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input word
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // captured_period[15:0], tick_ms[25:16], zero pad
  input  logic                  s_tuser,   // kind[0]: 0 capture, 1 tick
  // result word
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // frequency_milli[31:0], rpm_milli[69:32], zero pad
  output logic                  m_tuser,   // low_frequency[0]
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  state_t state, state_next;

  // configuration registers
  logic [31:0] timer_clock_half_hz;
  logic [15:0] pulse_gap_limit_ms;
  logic [7:0]  magnet_count;

  // monitor state
  logic [16:0] gap_elapsed_ms;
  logic        low_frequency_flag;
  logic [1:0]  hysteresis_count;
  logic        pulse_pending;
  logic [15:0] held_period;
  logic [31:0] held_frequency;

  // result being built
  logic [31:0] freq_milli;
  logic [37:0] rpm_milli;

  logic        in_accept;
  logic        is_tick;
  logic [15:0] in_period;
  logic [9:0]  in_delta;
  logic        need_freq_div;

  logic [15:0]           mul_scale;
  logic [47:0]           product;
  div_ctrl_t             div_ctrl;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quotient;
  logic                  out_free;

  assign in_accept     = s_tvalid && s_tready;
  assign is_tick       = (item_kind_t'(s_tuser) == KIND_TICK);
  assign in_period     = s_tdata[15:0];
  assign in_delta      = s_tdata[25:16];
  assign need_freq_div = is_tick && !low_frequency_flag && (held_period != 16'd0);
  assign out_free      = !m_tvalid || m_tready;
  assign s_tready      = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  // Shared multiplier: held frequency by the milli scale of the current pass.
  assign product = {16'd0, held_frequency} * {32'd0, mul_scale};

  ppfm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = need_freq_div ? ST_DIV_FREQ : ST_MUL_FREQ;
        end
      end
      ST_DIV_FREQ: begin
        if (div_done) begin
          state_next = ST_MUL_FREQ;
        end
      end
      ST_MUL_FREQ: state_next = ST_MUL_RPM;
      ST_MUL_RPM: begin
        state_next = (magnet_count == 8'd0) ? ST_OUT : ST_DIV_RPM;
      end
      ST_DIV_RPM: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier scale and divider launch.
  always_comb begin
    mul_scale      = RPM_MILLI_SCALE;
    div_ctrl.start = 1'b0;
    div_ctrl.steps = DIV_STEPS_RPM;
    div_dividend   = product;
    div_divisor    = {8'd0, magnet_count};
    unique case (state)
      ST_IDLE: begin
        // Place the clock in the top bits so 32 steps leave the quotient low.
        div_ctrl.start = in_accept && need_freq_div;
        div_ctrl.steps = DIV_STEPS_FREQ;
        div_dividend   = {timer_clock_half_hz, 16'd0};
        div_divisor    = held_period;
      end
      ST_MUL_FREQ: mul_scale = FREQ_MILLI_SCALE;
      ST_MUL_RPM: begin
        div_ctrl.start = (magnet_count != 8'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Register writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_half_hz <= TIMER_CLOCK_RESET;
      pulse_gap_limit_ms  <= GAP_LIMIT_RESET;
      magnet_count        <= MAGNET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMER_CLOCK:  timer_clock_half_hz <= cfg_data;
        REG_GAP_LIMIT:    pulse_gap_limit_ms  <= cfg_data[15:0];
        REG_MAGNET_COUNT: magnet_count        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Monitor state. Everything but the new frequency settles on the accept
  // edge; the frequency lands when the divider reports done.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_elapsed_ms     <= '0;
      low_frequency_flag <= 1'b1;
      hysteresis_count   <= '0;
      pulse_pending      <= 1'b0;
      held_period        <= '0;
      held_frequency     <= '0;
    end else begin
      if (in_accept && !is_tick) begin
        held_period   <= in_period;
        pulse_pending <= 1'b1;
      end else if (in_accept) begin
        // Frequency update uses the flag as it stood before this tick.
        if (low_frequency_flag) begin
          held_frequency <= '0;
        end else if (held_period != 16'd0) begin
          held_period <= '0;
        end
        if (pulse_pending) begin
          pulse_pending <= 1'b0;
          // Count a quick pulse only strictly below the limit.
          if (gap_elapsed_ms < {1'b0, pulse_gap_limit_ms}) begin
            if (hysteresis_count > 2'd1) begin
              low_frequency_flag <= 1'b0;
            end else begin
              hysteresis_count <= hysteresis_count + 2'd1;
            end
          end
          gap_elapsed_ms <= '0;
        end else if (gap_elapsed_ms > {1'b0, pulse_gap_limit_ms}) begin
          low_frequency_flag <= 1'b1;
          hysteresis_count   <= '0;
        end else begin
          gap_elapsed_ms <= gap_elapsed_ms + {7'd0, in_delta};
        end
      end
      if (state == ST_DIV_FREQ && div_done) begin
        held_frequency <= div_quotient[31:0];
      end
    end
  end

  // Milli results: saturate the frequency product; divide and saturate the rpm product, or zero it with no magnets.
  always_ff @(posedge clk) begin
    if (state == ST_MUL_FREQ) begin
      freq_milli <= (product[47:32] != 16'd0) ? '1 : product[31:0];
    end
    if (state == ST_MUL_RPM && magnet_count == 8'd0) begin
      rpm_milli <= '0;
    end
    if (state == ST_DIV_RPM && div_done) begin
      rpm_milli <= (div_quotient[47:38] != 10'd0) ? '1 : div_quotient[37:0];
    end
  end

  // Output register: load when free, hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {2'b00, rpm_milli, freq_milli};
      m_tuser <= low_frequency_flag;
    end
  end

endmodule

>>> hdl/ppfm_checker.sv
// Port-level checks of the pulse frequency monitor and their binding.
`include "pedal_pulse_frequency_monitor_defines.svh"

module ppfm_checker import ppfm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result word holds its payload.
  `PPFM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word dropped or changed while stalled")

  // Each accepted word keeps the block busy for at least the next cycle.
  `PPFM_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input taken again right after a word")

  // No result is pending right after reset.
  `PPFM_ASSERT_NOW(a_quiet_after_reset, clk, rst, $past(rst), !m_tvalid, "result word shown right after reset")

  // Zero frequency always comes with zero rpm and a clean pad.
  `PPFM_ASSERT_NOW(a_rpm_zero, clk, rst, m_tvalid && m_tdata[31:0] == 32'd0, m_tdata[71:32] == 40'd0, "rpm nonzero while frequency is zero")

endmodule

bind pedal_pulse_frequency_monitor ppfm_checker u_ppfm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/sv/tb_top.sv
// Self-checking bench for the pedal pulse frequency monitor: directed and random words.
`timescale 1ns / 1ps

module tb_top;
  import ppfm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = CFG_IDX_W'(REG_MAGNET_COUNT)
                                                        + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNMAPPED  = '1;
  localparam logic [63:0]          FREQ_CEILING       = 64'hFFFF_FFFF;
  localparam logic [63:0]          RPM_CEILING        = 64'h3F_FFFF_FFFF;
  localparam int                   WORDS_PER_PHASE    = 225;
  localparam int                   SETTLE_CYCLES      = 120;

  // One expected result word.
  typedef struct packed {
    logic [31:0] freq_milli;
    logic [37:0] rpm_milli;
    logic        low_freq;
  } pedal_result_t;

  // Tracks the monitor's registers and state, and holds the result words still owed.
  class ppfm_scoreboard;
    logic [31:0]   clock_half_hz;
    logic [15:0]   gap_limit;
    logic [7:0]    magnets;
    logic [16:0]   gap_ms;
    logic          low_freq;
    logic [1:0]    quick_count;
    logic          pending;
    logic [15:0]   period_q;
    logic [31:0]   freq_hz;
    pedal_result_t owed_q[$];
    int            errors;

    function new();
      clock_half_hz = TIMER_CLOCK_RESET;
      gap_limit     = GAP_LIMIT_RESET;
      magnets       = MAGNET_RESET;
      gap_ms        = '0;
      low_freq      = 1'b1;
      quick_count   = '0;
      pending       = 1'b0;
      period_q      = '0;
      freq_hz       = '0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_TIMER_CLOCK:  clock_half_hz = value;
        REG_GAP_LIMIT:    gap_limit     = value[15:0];
        REG_MAGNET_COUNT: magnets       = value[7:0];
        default: ;
      endcase
    endfunction

    // Advance the state by one accepted word and queue the result it owes.
    function void note_word(item_kind_t kind, logic [15:0] period, logic [9:0] delta);
      pedal_result_t want;
      logic [63:0]   scaled;
      if (kind == KIND_CAPTURE) begin
        period_q = period;
        pending  = 1'b1;
      end else begin
        // Frequency first, from the flag as it stood before this tick.
        if (low_freq) begin
          freq_hz = '0;
        end else if (period_q != '0) begin
          freq_hz  = clock_half_hz / {16'd0, period_q};
          period_q = '0;
        end
        // Then judge the pending pulse, or the silence, against the limit.
        if (pending) begin
          pending = 1'b0;
          if (gap_ms < {1'b0, gap_limit}) begin
            if (quick_count > 2'd1) low_freq = 1'b0;
            else quick_count = quick_count + 2'd1;
          end
          gap_ms = '0;
        end else if (gap_ms > {1'b0, gap_limit}) begin
          low_freq    = 1'b1;
          quick_count = '0;
        end else begin
          gap_ms = gap_ms + {7'd0, delta};
        end
      end
      scaled = {32'd0, freq_hz} * 64'd1000;
      want.freq_milli = (scaled > FREQ_CEILING) ? FREQ_CEILING[31:0] : scaled[31:0];
      if (magnets == '0) begin
        want.rpm_milli = '0;
      end else begin
        scaled = ({32'd0, freq_hz} * 64'd60000) / {56'd0, magnets};
        want.rpm_milli = (scaled > RPM_CEILING) ? RPM_CEILING[37:0] : scaled[37:0];
      end
      want.low_freq = low_freq;
      owed_q.push_back(want);
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] tdata, logic tuser);
      pedal_result_t want;
      if (owed_q.size() == 0) begin
        $error("result word arrived with no expectation waiting");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (tdata[31:0] !== want.freq_milli) begin
        $error("frequency_milli: expected %0d, actual %0d", want.freq_milli, tdata[31:0]);
        errors++;
      end
      if (tdata[69:32] !== want.rpm_milli) begin
        $error("rpm_milli: expected %0d, actual %0d", want.rpm_milli, tdata[69:32]);
        errors++;
      end
      if (tuser !== want.low_freq) begin
        $error("low_frequency: expected %0d, actual %0d", want.low_freq, tuser);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // captured_period[15:0], tick_ms[25:16], zero pad
  logic                  s_tuser = 1'b0; // kind[0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // frequency_milli[31:0], rpm_milli[69:32], zero pad
  logic                  m_tuser;        // low_frequency[0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [31:0]           cfg_data = '0;

  ppfm_scoreboard sb = new();
  int             calm_left = 0;

  pedal_pulse_frequency_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("pedal_pulse_frequency_monitor: mismatch");
    $finish;
  end

  // Gap after a word: mostly none or short, a few long, and now and then a calm run.
  function automatic int idle_gap();
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm_left = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Present one word and hold it until taken; valid stays high when no gap follows.
  task automatic send_word(input item_kind_t kind, input logic [15:0] period,
                           input logic [9:0] delta);
    int gap;
    gap = idle_gap();
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, delta, period};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(kind, period, delta);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Write all three registers plus one unmapped index; upper bits carry noise.
  task automatic program_regs(input logic [31:0] clock_half, input logic [15:0] limit,
                              input logic [7:0] mags);
    write_register(REG_TIMER_CLOCK, clock_half);
    write_register(REG_GAP_LIMIT, {16'($urandom), limit});
    write_register(REG_MAGNET_COUNT, {24'($urandom), mags});
    write_register(CFG_IDX_W'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_UNMAPPED)),
                   $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every owed result word.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Mostly pulse trains fast enough to count as quick, plus silences and noise.
  task automatic run_random(input int count);
    int          sent;
    int          mode;
    int          reps;
    int          ticks;
    int          span;
    logic [15:0] per;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        reps = $urandom_range(1, 8);
        for (int r = 0; r < reps; r++) begin
          per = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16))
                                            : 16'($urandom_range(0, 65535));
          send_word(KIND_CAPTURE, per, 10'($urandom_range(0, 1000)));
          ticks = $urandom_range(1, 3);
          // Keep the summed gap below the limit so the pulse counts as quick.
          span = (sb.gap_limit == '0) ? 0 : (int'(sb.gap_limit) - 1) / ticks;
          if (span > 1000) span = 1000;
          for (int t = 0; t < ticks; t++) begin
            send_word(KIND_TICK, 16'($urandom), 10'($urandom_range(0, span)));
          end
          sent += ticks + 1;
        end
      end else if (mode < 85) begin
        reps = $urandom_range(1, 6);
        for (int r = 0; r < reps; r++) begin
          send_word(KIND_TICK, 16'($urandom), 10'($urandom_range(0, 1000)));
        end
        sent += reps;
      end else begin
        reps = $urandom_range(1, 6);
        for (int r = 0; r < reps; r++) begin
          send_word(item_kind_t'($urandom_range(0, 1)), 16'($urandom),
                    10'($urandom_range(0, 1000)));
        end
        sent += reps;
      end
    end
  endtask

  // Receiver: random stalls, long stalls, and long stretches always ready.
  initial begin
    int roll;
    @(negedge rst);
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else if (roll < 13) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        m_tready <= 1'($urandom_range(0, 1));
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the reset register values.
    // Pulses while stopped: frequency stays forced to zero, ignored fields carry noise.
    send_word(KIND_CAPTURE, 16'hFFFF, 10'd1000);
    send_word(KIND_TICK,    16'hFFFF, 10'd0);
    send_word(KIND_CAPTURE, 16'd1,    10'd1000);
    send_word(KIND_TICK,    16'd0,    10'd499);
    send_word(KIND_TICK,    16'd0,    10'd499);
    // Third quick pulse just under the limit clears the low-frequency flag.
    send_word(KIND_CAPTURE, 16'd1,    10'd0);
    send_word(KIND_TICK,    16'd0,    10'd0);
    // Period of one: both milli outputs saturate.
    send_word(KIND_TICK,    16'd0,    10'd1);
    // Zero period leaves the frequency alone; an extra quick pulse keeps the flag clear.
    send_word(KIND_CAPTURE, 16'd0,    10'd0);
    send_word(KIND_TICK,    16'd0,    10'd2);
    send_word(KIND_CAPTURE, 16'hFFFF, 10'd0);
    send_word(KIND_TICK,    16'd0,    10'd0);
    // Gap grows to exactly the limit: no flag yet, and the next pulse is not quick.
    send_word(KIND_TICK,    16'd0,    10'd500);
    send_word(KIND_TICK,    16'd0,    10'd0);
    send_word(KIND_CAPTURE, 16'd2,    10'd0);
    send_word(KIND_TICK,    16'd0,    10'd0);
    // Silence past the limit: flag set with a stale frequency, then forced to zero.
    send_word(KIND_TICK,    16'd0,    10'd1000);
    send_word(KIND_TICK,    16'd0,    10'd0);
    send_word(KIND_TICK,    16'd0,    10'd0);
    // Pulse after a long gap resets the gap without counting as quick.
    send_word(KIND_CAPTURE, 16'd300,  10'd0);
    send_word(KIND_TICK,    16'd0,    10'd5);
    send_word(KIND_TICK,    16'h8000, 10'd512);
    drain();

    // Register settings, extremes first.
    program_regs(32'd1, 16'd0, 8'd0);
    run_random(WORDS_PER_PHASE);
    drain();
    program_regs(32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    run_random(WORDS_PER_PHASE);
    drain();
    program_regs(32'd0, 16'd20, 8'd3);
    run_random(WORDS_PER_PHASE);
    drain();
    program_regs(TIMER_CLOCK_RESET, GAP_LIMIT_RESET, MAGNET_RESET);
    run_random(WORDS_PER_PHASE);
    drain();
    program_regs($urandom, 16'($urandom_range(1, 2000)), 8'($urandom));
    run_random(WORDS_PER_PHASE);
    drain();
    program_regs($urandom_range(1, 200000), 16'($urandom_range(0, 50)), 8'($urandom));
    run_random(WORDS_PER_PHASE);
    drain();
    program_regs(32'hFFFF_FFFF, 16'd1, 8'd1);
    run_random(WORDS_PER_PHASE);
    drain();
    program_regs($urandom, 16'($urandom), 8'($urandom));
    run_random(WORDS_PER_PHASE);
    drain();

    // Let any stray result word show up before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("pedal_pulse_frequency_monitor: match");
    end else begin
      $display("pedal_pulse_frequency_monitor: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ppfm_pkg.sv
hdl/ppfm_div.sv
hdl/pedal_pulse_frequency_monitor.sv
hdl/ppfm_checker.sv
tb/sv/tb_top.sv
